// ===== hw/rtl/mcdp_pkg.sv =====
// Shared types, codes and constants of the multicycle datapath.
package mcdp_pkg;

    localparam int WORD_W    = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [REG_AW-1:0] t_reg_addr;

    localparam t_word     START_RESET = 32'h0040_0000;
    localparam t_reg_addr SYSCALL_REG = 5'd2;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;
    localparam logic [1:0] MEM_RSVD  = 2'd3;

    localparam logic [1:0] BSEL_B      = 2'd0;
    localparam logic [1:0] BSEL_FOUR   = 2'd1;
    localparam logic [1:0] BSEL_IMM    = 2'd2;
    localparam logic [1:0] BSEL_IMM_SH = 2'd3;

    localparam logic [1:0] ALU_ADD  = 2'd0;
    localparam logic [1:0] ALU_SUB  = 2'd1;
    localparam logic [1:0] ALU_FUNC = 2'd2;

    localparam logic [1:0] PCW_NONE   = 2'd0;
    localparam logic [1:0] PCW_ALWAYS = 2'd1;
    localparam logic [1:0] PCW_BRANCH = 2'd2;

    localparam logic [1:0] PCS_ALU    = 2'd0;
    localparam logic [1:0] PCS_ALUOUT = 2'd1;
    localparam logic [1:0] PCS_JUMP   = 2'd2;

    localparam logic [5:0] OP_SPECIAL  = 6'h00;
    localparam logic [5:0] OP_BEQ      = 6'h04;
    localparam logic [5:0] OP_BNE      = 6'h05;
    localparam logic [5:0] OP_ADDI     = 6'h08;
    localparam logic [5:0] OP_ADDI_UNS = 6'h09;
    localparam logic [5:0] OP_SLTI     = 6'h0A;
    localparam logic [5:0] OP_SLTI_UNS = 6'h0B;
    localparam logic [5:0] OP_ANDI     = 6'h0C;
    localparam logic [5:0] OP_ORI      = 6'h0D;
    localparam logic [5:0] OP_XORI     = 6'h0E;
    localparam logic [5:0] OP_LUI      = 6'h0F;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    typedef struct packed {
        logic [1:0] mem_access;
        logic       addr_select;
        logic       alu_a_select;
        logic [1:0] alu_b_select;
        logic [1:0] alu_control;
        logic [1:0] pc_write_mode;
        logic [1:0] pc_source;
        logic       ir_write;
        logic       reg_write;
        logic       reg_dest_select;
        logic       write_from_memory;
    } t_uop;

    typedef struct packed {
        t_word y;
        logic  fault;
        logic  sysreq;
    } t_alu_res;

    typedef struct packed {
        logic      we;
        t_reg_addr addr;
        t_word     data;
    } t_rf_wr;

endpackage

// ===== hw/rtl/mcdp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mcdp_regfile.sv =====
// Register file: two RAM read ports with valid bits, write forwarding and a copy of register 2.
module mcdp_regfile import mcdp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_rf_wr    i_wr,
    input  t_reg_addr i_raddr [2],
    output t_word     o_rdata [2],
    output t_word     o_reg2
);

    logic [REG_COUNT-1:0] r_vld;
    logic [REG_COUNT-1:0] n_vld;
    t_word                r_wdata;
    t_word                r_reg2;
    logic                 wr_en;

    assign wr_en = i_en && i_wr.we;

    always_comb begin
        n_vld = r_vld;
        if (wr_en) begin
            n_vld[i_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_reg2 <= '0;
        end else begin
            r_vld <= n_vld;
            if (wr_en && i_wr.addr == SYSCALL_REG) begin
                r_reg2 <= i_wr.data;
            end
        end
        if (i_en) begin
            r_wdata <= i_wr.data;
        end
    end

    for (genvar p = 0; p < 2; p++) begin : gen_port
        t_word ram_q;
        logic  r_fwd;
        logic  r_hit;

        mcdp_ram #(
            .WIDTH (WORD_W),
            .DEPTH (REG_COUNT)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en),
            .i_waddr (i_wr.addr),
            .i_wdata (i_wr.data),
            .i_re    (i_en),
            .i_raddr (i_raddr[p]),
            .o_rdata (ram_q)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fwd <= 1'b0;
                r_hit <= 1'b0;
            end else if (i_en) begin
                r_fwd <= wr_en && i_wr.addr == i_raddr[p];
                r_hit <= n_vld[i_raddr[p]];
            end
        end

        assign o_rdata[p] = !r_hit ? '0 : (r_fwd ? r_wdata : ram_q);
    end

    assign o_reg2 = r_reg2;

endmodule

// ===== hw/rtl/mcdp_alu.sv =====
// Operand selection, function decode and ALU.
module mcdp_alu import mcdp_pkg::*; (
    input  t_uop     i_uop,
    input  t_word    i_pc,
    input  t_word    i_a,
    input  t_word    i_b,
    input  t_word    i_ir,
    output t_alu_res o_res
);

    t_word      a;
    t_word      b;
    t_word      imm;
    logic [5:0] opcode;
    logic [5:0] funct;
    logic [4:0] shamt;
    logic       slt;
    logic       sltu;

    assign opcode = i_ir[31:26];
    assign funct  = i_ir[5:0];
    assign shamt  = i_ir[10:6];
    assign imm    = {{16{i_ir[15]}}, i_ir[15:0]};
    assign a      = i_uop.alu_a_select ? i_a : i_pc;
    assign slt    = $signed(a) < $signed(b);
    assign sltu   = a < b;

    always_comb begin
        unique case (i_uop.alu_b_select)
            BSEL_B:    b = i_b;
            BSEL_FOUR: b = 32'd4;
            BSEL_IMM:  b = imm;
            default:   b = {imm[29:0], 2'b00};
        endcase
    end

    always_comb begin
        o_res = '0;
        unique case (i_uop.alu_control)
            ALU_ADD: o_res.y = a + b;
            ALU_SUB: o_res.y = a - b;
            ALU_FUNC: begin
                if (opcode == OP_SPECIAL) begin
                    unique case (funct)
                        FN_SYSCALL:      o_res.sysreq = 1'b1;
                        FN_SLL:          o_res.y = b << shamt;
                        FN_SRL:          o_res.y = b >> shamt;
                        FN_AND:          o_res.y = a & b;
                        FN_OR:           o_res.y = a | b;
                        FN_XOR:          o_res.y = a ^ b;
                        FN_NOR:          o_res.y = ~(a | b);
                        FN_SLT:          o_res.y = {31'd0, slt};
                        FN_SLTU:         o_res.y = {31'd0, sltu};
                        FN_ADD, FN_ADDU: o_res.y = a + b;
                        FN_SUB, FN_SUBU: o_res.y = a - b;
                        default:         o_res.fault = 1'b1;
                    endcase
                end else begin
                    unique case (opcode)
                        OP_ADDI, OP_ADDI_UNS: o_res.y = a + b;
                        OP_SLTI:              o_res.y = {31'd0, slt};
                        OP_SLTI_UNS:          o_res.y = {31'd0, sltu};
                        OP_ANDI:              o_res.y = a & b;
                        OP_ORI:               o_res.y = a | b;
                        OP_XORI:              o_res.y = a ^ b;
                        OP_LUI:               o_res.y = {b[15:0], 16'd0};
                        default:              o_res.fault = 1'b1;
                    endcase
                end
            end
            default: o_res.fault = 1'b1;
        endcase
    end

endmodule

// ===== hw/rtl/multicycle_cpu_datapath.sv =====
// Multicycle datapath top level: input register, execute step, result register.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------
//  in       | sink      | i_in_valid / o_in_ready    | microinstruction + read word
//  out      | source    | o_out_valid / i_out_ready  | strobes, address, ALU, PC, ...
//  cfg      | sink      | i_cfg_valid / o_cfg_ready  | start address (loads PC)
//
//  One beat per cycle sustained while the output is not stalled; each beat passes the input
//  register and then the result register around the single ALU and register file pass.
//  Reset is synchronous: PC takes 0x00400000, register file valid bits clear at once.
//  A stalled result holds in the output register while one more beat waits in the
//  input register.
module multicycle_cpu_datapath import mcdp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mem_access,
    input  logic        i_addr_select,
    input  logic        i_alu_a_select,
    input  logic [1:0]  i_alu_b_select,
    input  logic [1:0]  i_alu_control,
    input  logic [1:0]  i_pc_write_mode,
    input  logic [1:0]  i_pc_source,
    input  logic        i_ir_write,
    input  logic        i_reg_write,
    input  logic        i_reg_dest_select,
    input  logic        i_write_from_memory,
    input  logic [31:0] i_read_word,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_mem_read_strobe,
    output logic        o_mem_write_strobe,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_store_data,
    output logic [31:0] o_alu_result,
    output logic [31:0] o_program_counter,
    output logic [31:0] o_stored_alu_result,
    output logic [5:0]  o_current_opcode,
    output logic        o_syscall_request,
    output logic [31:0] o_syscall_code,
    output logic        o_fault
);

    logic      r_in_vld;
    t_uop      r_uop;
    t_word     r_rword;
    logic      r_out_vld;

    t_word     r_pc;
    t_word     r_ir;
    t_word     r_aluout;
    t_word     r_mdr;
    t_word     n_pc;
    t_word     n_ir;

    logic      in_fire;
    logic      exec;
    logic      cfg_fire;
    t_alu_res  alu;
    t_word     a_latch;
    t_word     b_latch;
    t_word     reg2;
    t_word     rf_rdata [2];
    t_reg_addr rf_raddr [2];
    t_rf_wr    rf_wr;

    t_word     address;
    logic      rd_strobe;
    logic      wr_strobe;
    t_word     word;
    logic      pcw;
    logic      pc_fault;
    logic      fault;
    t_reg_addr dest;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign exec        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || exec;
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (exec) begin
            r_in_vld <= 1'b0;
        end
        if (in_fire) begin
            r_uop.mem_access        <= i_mem_access;
            r_uop.addr_select       <= i_addr_select;
            r_uop.alu_a_select      <= i_alu_a_select;
            r_uop.alu_b_select      <= i_alu_b_select;
            r_uop.alu_control       <= i_alu_control;
            r_uop.pc_write_mode     <= i_pc_write_mode;
            r_uop.pc_source         <= i_pc_source;
            r_uop.ir_write          <= i_ir_write;
            r_uop.reg_write         <= i_reg_write;
            r_uop.reg_dest_select   <= i_reg_dest_select;
            r_uop.write_from_memory <= i_write_from_memory;
            r_rword                 <= i_read_word;
        end
    end

    mcdp_alu u_alu (
        .i_uop (r_uop),
        .i_pc  (r_pc),
        .i_a   (a_latch),
        .i_b   (b_latch),
        .i_ir  (r_ir),
        .o_res (alu)
    );

    assign address   = r_uop.addr_select ? r_aluout : r_pc;
    assign rd_strobe = r_uop.mem_access == MEM_READ;
    assign wr_strobe = r_uop.mem_access == MEM_WRITE;
    assign word      = rd_strobe ? r_rword : '0;

    always_comb begin
        pcw      = 1'b0;
        pc_fault = 1'b0;
        unique case (r_uop.pc_write_mode)
            PCW_NONE:   pcw = 1'b0;
            PCW_ALWAYS: pcw = 1'b1;
            PCW_BRANCH: pcw = (r_ir[31:26] == OP_BNE && alu.y != '0)
                           || (r_ir[31:26] == OP_BEQ && alu.y == '0);
            default:    pc_fault = 1'b1;
        endcase
        n_pc = r_pc;
        if (pcw) begin
            unique case (r_uop.pc_source)
                PCS_ALU:    n_pc = alu.y;
                PCS_ALUOUT: n_pc = r_aluout;
                PCS_JUMP:   n_pc = {r_pc[31:28], r_ir[25:0], 2'b00};
                default:    pc_fault = 1'b1;
            endcase
        end
    end

    assign fault = alu.fault || pc_fault
                || r_uop.mem_access == MEM_RSVD
                || (wr_strobe && !r_uop.addr_select);

    assign n_ir = r_uop.ir_write ? word : r_ir;
    assign dest = r_uop.reg_dest_select ? n_ir[15:11] : n_ir[20:16];

    assign rf_wr.we   = r_uop.reg_write && dest != '0;
    assign rf_wr.addr = dest;
    assign rf_wr.data = r_uop.write_from_memory ? r_mdr : r_aluout;
    assign rf_raddr[0] = n_ir[25:21];
    assign rf_raddr[1] = n_ir[20:16];

    mcdp_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (exec),
        .i_wr    (rf_wr),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata),
        .o_reg2  (reg2)
    );

    assign a_latch = rf_rdata[0];
    assign b_latch = rf_rdata[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= START_RESET;
            r_ir      <= '0;
            r_aluout  <= '0;
            r_mdr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_pc <= i_cfg_data;
            end else if (exec) begin
                r_pc <= n_pc;
            end
            if (exec) begin
                r_ir      <= n_ir;
                r_aluout  <= alu.y;
                r_mdr     <= word;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (exec) begin
            o_mem_read_strobe   <= rd_strobe;
            o_mem_write_strobe  <= wr_strobe;
            o_mem_address       <= address;
            o_store_data        <= b_latch;
            o_alu_result        <= alu.y;
            o_program_counter   <= n_pc;
            o_stored_alu_result <= alu.y;
            o_current_opcode    <= n_ir[31:26];
            o_syscall_request   <= alu.sysreq;
            o_syscall_code      <= alu.sysreq ? reg2 : '0;
            o_fault             <= fault;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== hw/rtl/mcdp_checker.sv =====
// Port-level checker for the multicycle datapath, bound to the top level.
module mcdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_mem_read_strobe,
    input logic        o_mem_write_strobe,
    input logic [31:0] o_alu_result,
    input logic [31:0] o_stored_alu_result,
    input logic [31:0] o_program_counter,
    input logic        o_syscall_request,
    input logic [31:0] o_syscall_code
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_program_counter))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_read_strobe && o_mem_write_strobe))
        else $error("read and write strobes together");

    a_aluout_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_stored_alu_result == o_alu_result)
        else $error("ALU-out latch differs from ALU result");

    a_syscall_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_syscall_request |-> o_syscall_code == 32'd0)
        else $error("syscall code without request");

endmodule

bind multicycle_cpu_datapath mcdp_checker u_mcdp_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_mem_read_strobe   (o_mem_read_strobe),
    .o_mem_write_strobe  (o_mem_write_strobe),
    .o_alu_result        (o_alu_result),
    .o_stored_alu_result (o_stored_alu_result),
    .o_program_counter   (o_program_counter),
    .o_syscall_request   (o_syscall_request),
    .o_syscall_code      (o_syscall_code)
);
